// ----- hw/rtl/two_channel_poly_tone_generator_core_macros.svh -----
// Assertion macros for the two-channel poly tone generator core.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef TWO_CHANNEL_POLY_TONE_GENERATOR_CORE_MACROS_SVH
`define TWO_CHANNEL_POLY_TONE_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TCPTG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcptg assertion failed");
`define TCPTG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tcptg assertion failed");
`else
`define TCPTG_ASSERT(label, clk, rst_n, prop)
`define TCPTG_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- hw/rtl/tcptg_pkg.sv -----
// Package for the two-channel poly tone generator core: channel state type,
// codes and waveform tables. No dependencies.
`default_nettype none

package tcptg_pkg;

    localparam int NumChannels = 2;

    // Operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register address bits [2:1] select the register kind, bit 0 the channel.
    localparam logic [1:0] KIND_CTRL = 2'd0;
    localparam logic [1:0] KIND_FREQ = 2'd1;
    localparam logic [1:0] KIND_VOL  = 2'd2;

    // Smoothing modes.
    localparam logic [1:0] SMOOTH_RAW  = 2'd0;
    localparam logic [1:0] SMOOTH_PAIR = 2'd1;

    localparam logic [7:0] PAUSE_SAMPLE = 8'h80;

    // Control modes.
    localparam logic [3:0] MODE_HOLD      = 4'd0;
    localparam logic [3:0] MODE_POLY4     = 4'd1;
    localparam logic [3:0] MODE_D31_P4    = 4'd2;
    localparam logic [3:0] MODE_P5_P4     = 4'd3;
    localparam logic [3:0] MODE_TOG_A     = 4'd4;
    localparam logic [3:0] MODE_TOG_B     = 4'd5;
    localparam logic [3:0] MODE_D31_TOG_A = 4'd6;
    localparam logic [3:0] MODE_POLY5_A   = 4'd7;
    localparam logic [3:0] MODE_POLY9     = 4'd8;
    localparam logic [3:0] MODE_POLY5_B   = 4'd9;
    localparam logic [3:0] MODE_D31_TOG_B = 4'd10;
    localparam logic [3:0] MODE_P5_SET    = 4'd11;
    localparam logic [3:0] MODE_D6_A      = 4'd12;
    localparam logic [3:0] MODE_D6_B      = 4'd13;
    localparam logic [3:0] MODE_D31_D6    = 4'd14;
    localparam logic [3:0] MODE_P5_D6     = 4'd15;

    // Waveform tables, bit i holds step i.
    localparam logic [14:0] TAB_P4  = 15'b111_0000_1010_0110;
    localparam logic [30:0] TAB_P5  = 31'b1100_1011_0111_1010_1000_1001_1100_000;
    localparam logic [30:0] TAB_P5T = 31'b0101_1101_1000_1111_1001_1010_0100_001;
    localparam logic [30:0] TAB_D31 = 31'h0008_0002;
    localparam logic [5:0]  TAB_D6  = 6'b010010;

    localparam logic [3:0] P4_LAST = 4'd14;
    localparam logic [4:0] P5_LAST = 5'd30;
    localparam logic [2:0] D6_LAST = 3'd5;

    typedef struct packed {
        logic [3:0] control;
        logic [4:0] freq;
        logic [3:0] volume;
        logic [6:0] out_level;
        logic [5:0] div_count;
        logic [5:0] div_reload;
        logic [3:0] poly4_pos;
        logic [4:0] poly5_pos;
        logic [2:0] div6_pos;
        logic [8:0] poly9_shift;
    } t_chan_state;

    localparam t_chan_state CHAN_RESET = '{poly9_shift: 9'd1, default: '0};

endpackage

`default_nettype wire

// ----- hw/rtl/two_channel_poly_tone_generator_core.sv -----
// Two-channel poly tone generator core: register writes and sample ticks in,
// mixed 8-bit samples out. Depends on tcptg_pkg and the assertion macro header.
//
// Each input transaction is either a register write or a sample tick. A tick
// yields exactly one 8-bit sample; a write yields none. One transaction is
// taken every clock cycle unless o_stall is raised. A tick passes through the
// input register and then the result register, with both channels' divider,
// waveform and mixing logic between them. The input register holds a tick
// while the output side stalls; a write is not held there, so writes keep
// flowing behind a waiting sample. The smoothing mode may be written only
// while no transaction is in flight.
`default_nettype none
`include "two_channel_poly_tone_generator_core_macros.svh"

module two_channel_poly_tone_generator_core
    import tcptg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_smoothing_mode_we,
    input  wire logic [1:0] i_smoothing_mode,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_operation,
    input  wire logic [2:0] i_reg_address,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_paused,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_sample
);

    logic [1:0]  r_smooth;
    logic        r_in_valid;
    logic        r_in_op;
    logic [2:0]  r_in_addr;
    logic [7:0]  r_in_data;
    logic        r_in_paused;
    logic        r_out_valid;
    logic [7:0]  r_out_sample;
    logic [7:0]  r_last;
    t_chan_state r_ch [NumChannels];

    t_chan_state n_ch [NumChannels];
    logic [7:0]  n_last;
    logic [7:0]  n_sample;

    logic out_free;
    logic process;
    logic accept;

    assign out_free = !r_out_valid || !i_stall;
    assign process  = r_in_valid && ((r_in_op == OP_WRITE) || out_free);
    assign o_stall  = r_in_valid && !process;
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;

    always_comb begin
        t_chan_state ch;
        logic [5:0]  nv;
        logic [6:0]  vol7;
        logic [7:0]  mix;
        logic [8:0]  acc;
        logic        d31_hit;
        logic        p5t_hit;
        n_ch     = r_ch;
        n_last   = r_last;
        n_sample = '0;
        mix      = '0;
        acc      = '0;
        for (int c = 0; c < NumChannels; c++) begin
            ch      = r_ch[c];
            nv      = '0;
            vol7    = '0;
            d31_hit = 1'b0;
            p5t_hit = 1'b0;
            if (process && r_in_op == OP_WRITE) begin
                if (r_in_addr[0] == 1'(c) && r_in_addr[2:1] != 2'd3) begin
                    case (r_in_addr[2:1])
                        KIND_CTRL: ch.control = r_in_data[3:0];
                        KIND_FREQ: ch.freq    = r_in_data[4:0];
                        KIND_VOL:  ch.volume  = r_in_data[3:0];
                        default:   ch.control = r_ch[c].control;
                    endcase
                    if (ch.control == MODE_HOLD) begin
                        nv           = '0;
                        ch.out_level = {ch.volume, 3'b000};
                    end else begin
                        nv = {1'b0, ch.freq} + 6'd1;
                    end
                    if (nv != ch.div_reload) begin
                        ch.div_reload = nv;
                        if (ch.div_count == '0 || nv == '0) begin
                            ch.div_count = nv;
                        end
                    end
                end
            end else if (process && ch.div_count != '0) begin
                if (ch.div_count != 6'd1) begin
                    ch.div_count = ch.div_count - 6'd1;
                end else begin
                    ch.div_count = ch.div_reload;
                    ch.poly5_pos = (ch.poly5_pos == P5_LAST) ? 5'd0 : ch.poly5_pos + 5'd1;
                    vol7    = {ch.volume, 3'b000};
                    d31_hit = TAB_D31[ch.poly5_pos];
                    p5t_hit = TAB_P5T[ch.poly5_pos];
                    case (ch.control) inside
                        MODE_POLY4, MODE_D31_P4, MODE_P5_P4: begin
                            if (ch.control == MODE_POLY4
                                || (ch.control == MODE_D31_P4 && d31_hit)
                                || (ch.control == MODE_P5_P4 && p5t_hit)) begin
                                ch.poly4_pos = (ch.poly4_pos == P4_LAST) ? 4'd0
                                             : ch.poly4_pos + 4'd1;
                                ch.out_level = TAB_P4[ch.poly4_pos] ? vol7 : 7'd0;
                            end
                        end
                        MODE_TOG_A, MODE_TOG_B: begin
                            ch.out_level = (ch.out_level == '0) ? vol7 : 7'd0;
                        end
                        MODE_D31_TOG_A, MODE_D31_TOG_B: begin
                            if (d31_hit) begin
                                ch.out_level = (ch.out_level == '0) ? vol7 : 7'd0;
                            end
                        end
                        MODE_POLY5_A, MODE_POLY5_B: begin
                            ch.out_level = TAB_P5[ch.poly5_pos] ? vol7 : 7'd0;
                        end
                        MODE_POLY9: begin
                            ch.poly9_shift = {ch.poly9_shift[0] ^ ch.poly9_shift[4],
                                              ch.poly9_shift[8:1]};
                            ch.out_level = ch.poly9_shift[0] ? vol7 : 7'd0;
                        end
                        MODE_P5_SET: begin
                            if (TAB_P5[ch.poly5_pos]) begin
                                ch.out_level = vol7;
                            end
                        end
                        MODE_D6_A, MODE_D6_B, MODE_D31_D6, MODE_P5_D6: begin
                            if (ch.control == MODE_D6_A || ch.control == MODE_D6_B
                                || (ch.control == MODE_D31_D6 && d31_hit)
                                || (ch.control == MODE_P5_D6 && p5t_hit)) begin
                                ch.div6_pos = (ch.div6_pos == D6_LAST) ? 3'd0
                                            : ch.div6_pos + 3'd1;
                                if (TAB_D6[ch.div6_pos]) begin
                                    ch.out_level = (ch.out_level == '0) ? vol7 : 7'd0;
                                end
                            end
                        end
                        default: ch.out_level = ch.out_level;
                    endcase
                end
            end
            n_ch[c] = ch;
        end
        mix = {1'b0, n_ch[0].out_level} + {1'b0, n_ch[1].out_level};
        if (r_in_paused) begin
            mix = PAUSE_SAMPLE;
        end
        n_sample = mix;
        if (process && r_in_op == OP_TICK && r_smooth != SMOOTH_RAW) begin
            acc      = {1'b0, r_last} + {1'b0, mix};
            n_sample = acc[8:1];
            n_last   = (r_smooth == SMOOTH_PAIR) ? mix : acc[8:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth    <= SMOOTH_RAW;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            for (int c = 0; c < NumChannels; c++) begin
                r_ch[c] <= CHAN_RESET;
            end
        end else begin
            if (i_smoothing_mode_we) begin
                r_smooth <= i_smoothing_mode;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= process && (r_in_op == OP_TICK);
            end
            r_ch   <= n_ch;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_op     <= i_operation;
            r_in_addr   <= i_reg_address;
            r_in_data   <= i_write_data;
            r_in_paused <= i_paused;
        end
        if (process && r_in_op == OP_TICK) begin
            r_out_sample <= n_sample;
        end
    end

    `TCPTG_ASSERT(a_write_never_stalls, i_clk, i_rst_n,
        (r_in_valid && r_in_op == OP_WRITE) |-> !o_stall)
    `TCPTG_ASSERT(a_tick_yields_sample, i_clk, i_rst_n,
        (process && r_in_op == OP_TICK) |=> o_valid)
    `TCPTG_ASSERT(a_paused_raw_is_mid, i_clk, i_rst_n,
        (process && r_in_op == OP_TICK && r_in_paused && r_smooth == SMOOTH_RAW)
            |=> (o_sample == PAUSE_SAMPLE))
    `TCPTG_ASSERT(a_halted_ch0_holds, i_clk, i_rst_n,
        (process && r_in_op == OP_TICK && r_ch[0].div_count == '0)
            |=> $stable(r_ch[0].out_level))
    `TCPTG_ASSERT(a_no_sample_from_write, i_clk, i_rst_n,
        (process && r_in_op == OP_WRITE && !r_out_valid) |=> !o_valid)

endmodule

`default_nettype wire
